>>> rtl/rcpa_pkg.sv
// Package for the reference-counted page allocator.
// Field widths, request and status codes, register indexes and reset values.
// No dependencies.
package rcpa_pkg;

    localparam int ADDR_W   = 40;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int RCOUT_W  = 16;
    localparam int CFG_IX_W = 2;

    // defaults for the top level parameters
    localparam int DEF_NUM_PAGES  = 32768;
    localparam int DEF_PAGE_SIZE  = 4096;
    localparam int DEF_COUNT_BITS = 16;

    // request actions
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SHARE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

    // result status
    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVF = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_KEND = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_TOP  = 2'd2;

    localparam logic [ADDR_W-1:0] RST_BASE = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] RST_KEND = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] RST_TOP  = 40'h00_8800_0000;

    // address check result: page number relative to base
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] page;
    } t_chk;

endpackage

>>> rtl/rcpa_addr_check.sv
// Address check for free and share requests of the page allocator.
// Alignment, window and table range checks; depends on rcpa_pkg.
module rcpa_addr_check import rcpa_pkg::*; #(
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int PAGE_SHIFT = 12
) (
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [ADDR_W-1:0] i_base,
    input  logic [ADDR_W-1:0] i_kend,
    input  logic [ADDR_W-1:0] i_top,
    output t_chk              o_chk
);

    logic [ADDR_W-1:0] w_off;
    logic [ADDR_W-1:0] w_page;
    logic              w_aligned;
    logic              w_window;

    assign w_off     = i_addr - i_base;
    assign w_page    = w_off >> PAGE_SHIFT;
    assign w_aligned = (i_addr[PAGE_SHIFT-1:0] == '0);
    assign w_window  = (i_addr >= i_kend) && (i_addr < i_top) && (i_addr >= i_base);

    assign o_chk.ok   = w_aligned && w_window && (w_page < ADDR_W'(NUM_PAGES));
    assign o_chk.page = w_page;

endmodule

>>> rtl/refcounted_page_allocator.sv
// Reference-counted page allocator: top level with count table and free stack.
// Uses rcpa_pkg and rcpa_addr_check.
//
// One request at a time: the accept cycle checks the address and reads the
// count memory and the free stack, then the update state (S_EXEC) updates
// both memories and loads the result register. The result register
// lets the next request enter while a result waits; a result that is not
// taken holds the update cycle. After reset the count memory is cleared one
// entry per cycle, and no request is accepted while it is cleared;
// configuration writes are taken at any time.
module refcounted_page_allocator import rcpa_pkg::*; #(
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int PAGE_SIZE  = DEF_PAGE_SIZE,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]   i_cfg_wdata,
    // requests
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [ADDR_W-1:0]   i_s_axis_tdata,   // [39:0] address
    input  logic [ACT_W-1:0]    i_s_axis_tuser,   // [1:0] action
    // results
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [63:0]         o_m_axis_tdata,   // [39:0] page_address, [55:40] ref_count,
                                                  // [56] page_freed, rest zero
    output logic [STAT_W-1:0]   o_m_axis_tuser    // [1:0] status
);

    localparam int IDX_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
    localparam int CEXT_W     = (COUNT_BITS > RCOUT_W) ? COUNT_BITS : RCOUT_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    // configuration registers
    logic [ADDR_W-1:0] r_base, r_kend, r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= RST_BASE;
            r_kend <= RST_KEND;
            r_top  <= RST_TOP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE: r_base <= i_cfg_wdata;
                CFG_KEND: r_kend <= i_cfg_wdata;
                CFG_TOP:  r_top  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // control
    logic [1:0]         r_state, n_state;
    logic [IDX_W-1:0]   r_clr, n_clr;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_out_valid, n_out_valid;

    // request held for the update cycle
    logic [ACT_W-1:0]   r_act;
    logic               r_ok;
    logic [IDX_W-1:0]   r_idx;

    // result register
    logic [STAT_W-1:0]  r_status, n_status;
    logic [ADDR_W-1:0]  r_paddr, n_paddr;
    logic [RCOUT_W-1:0] r_rc, n_rc;
    logic               r_freed, n_freed;

    // memories
    logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
    logic [IDX_W-1:0]      stk_mem [NUM_PAGES];
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic [IDX_W-1:0]      r_stk_rd;

    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  stk_we;

    t_chk               w_chk;
    logic               w_accept;
    logic               w_go;
    logic [DEPTH_W-1:0] w_depth_m1;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [CEXT_W-1:0]  w_cext;

    rcpa_addr_check #(
        .NUM_PAGES (NUM_PAGES),
        .PAGE_SHIFT(PAGE_SHIFT)
    ) u_chk (
        .i_addr(i_s_axis_tdata),
        .i_base(r_base),
        .i_kend(r_kend),
        .i_top (r_top),
        .o_chk (w_chk)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_go            = (r_state == S_EXEC) && (!r_out_valid || i_m_axis_tready);
    assign w_depth_m1      = r_depth - DEPTH_W'(1);

    // memory ports: reads in the accept cycle, writes in the update cycle and while clearing
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (w_accept) begin
            r_cnt_rd <= cnt_mem[w_chk.page[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[r_depth[IDX_W-1:0]] <= r_idx;
        end
        if (w_accept) begin
            r_stk_rd <= stk_mem[w_depth_m1[IDX_W-1:0]];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_depth     = r_depth;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_status    = r_status;
        n_paddr     = r_paddr;
        n_rc        = r_rc;
        n_freed     = r_freed;
        cnt_we      = 1'b0;
        cnt_waddr   = r_idx;
        cnt_wdata   = '0;
        stk_we      = 1'b0;
        w_cnt       = '0;

        unique case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                n_clr     = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = STAT_OK;
                    n_paddr     = '0;
                    n_freed     = 1'b0;
                    case (r_act)
                        ACT_ALLOC: begin
                            if (r_depth == '0) begin
                                n_status = STAT_OOM;
                            end else begin
                                n_depth   = w_depth_m1;
                                cnt_we    = 1'b1;
                                cnt_waddr = r_stk_rd;
                                cnt_wdata = CNT_ONE;
                                w_cnt     = CNT_ONE;
                                n_paddr   = r_base + (ADDR_W'(r_stk_rd) << PAGE_SHIFT);
                            end
                        end
                        ACT_FREE: begin
                            if (!r_ok) begin
                                n_status = STAT_BAD;
                            end else if (r_cnt_rd > CNT_ONE) begin
                                cnt_we    = 1'b1;
                                cnt_wdata = r_cnt_rd - CNT_ONE;
                                w_cnt     = cnt_wdata;
                            end else begin
                                cnt_we = 1'b1;
                                if (r_depth >= DEPTH_W'(NUM_PAGES)) begin
                                    n_status = STAT_OVF;
                                end else begin
                                    stk_we  = 1'b1;
                                    n_depth = r_depth + DEPTH_W'(1);
                                    n_freed = 1'b1;
                                end
                            end
                        end
                        ACT_SHARE: begin
                            if (!r_ok) begin
                                n_status = STAT_BAD;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_wdata = (r_cnt_rd == CNT_MAX) ? r_cnt_rd
                                                                  : r_cnt_rd + CNT_ONE;
                                w_cnt     = cnt_wdata;
                            end
                        end
                        default: ;  // unused action: no effect
                    endcase
                    n_rc = w_cext[RCOUT_W-1:0];
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_cext = CEXT_W'(w_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_s_axis_tuser;
            r_ok  <= w_chk.ok;
            r_idx <= w_chk.page[IDX_W-1:0];
        end
        r_status <= n_status;
        r_paddr  <= n_paddr;
        r_rc     <= n_rc;
        r_freed  <= n_freed;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {7'd0, r_freed, r_rc, r_paddr};

endmodule
